// File: src/imual_pkg.sv
`default_nettype none

package imual_pkg;

	// Default sizes
	localparam int DEF_SAMPLE_BITS     = 16;
	localparam int DEF_COEF_FRAC_BITS  = 30;
	localparam int DEF_STATE_FRAC_BITS = 16;

	// Filter state width, fixed
	localparam int ST_BITS = 40;

	// Mounting matrix: nine 2-bit entries, row-major
	localparam int                ROT_BITS  = 18;
	localparam logic [ROT_BITS-1:0] ROT_RESET = 18'h10101;

	typedef enum logic [1:0] {
		ROT_ZERO  = 2'd0,
		ROT_PLUS  = 2'd1,
		ROT_MINUS = 2'd3
	} rot_code_t;

	// Configuration register map
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MOUNT_ROTATION = 3'd0,
		REG_GYRO_BIAS_X    = 3'd1,
		REG_GYRO_BIAS_Y    = 3'd2,
		REG_GYRO_BIAS_Z    = 3'd3,
		REG_ACCEL_BIAS_X   = 3'd4,
		REG_ACCEL_BIAS_Y   = 3'd5,
		REG_ACCEL_BIAS_Z   = 3'd6
	} cfg_reg_t;

	// Low-pass coefficients, Q2.30: a1, a2, b0 (sum is exactly 1.0)
	localparam int COEF_A1 = 0;
	localparam int COEF_A2 = 1;
	localparam int COEF_B0 = 2;

	localparam longint COEF_Q30 [3] = '{64'sd2071735500, -64'sd1000494913, 64'sd2501237};

	// Rescale a Q30 coefficient to cf fraction bits, round half up
	function automatic longint coef_scaled(input int k, input int cf);
		longint c;
		c = COEF_Q30[k];
		if (cf >= 30)
			return c <<< (cf - 30);
		return (c + (64'sd1 <<< (29 - cf))) >>> (30 - cf);
	endfunction

endpackage

`default_nettype wire

// File: src/imual_raw_if.sv
`default_nettype none

interface imual_raw_if #(
	parameter int SAMPLE_BITS = imual_pkg::DEF_SAMPLE_BITS
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] raw_gyro_x;
	logic signed [SAMPLE_BITS-1:0] raw_gyro_y;
	logic signed [SAMPLE_BITS-1:0] raw_gyro_z;
	logic signed [SAMPLE_BITS-1:0] raw_accel_x;
	logic signed [SAMPLE_BITS-1:0] raw_accel_y;
	logic signed [SAMPLE_BITS-1:0] raw_accel_z;

	modport source (
		output valid, raw_gyro_x, raw_gyro_y, raw_gyro_z,
		       raw_accel_x, raw_accel_y, raw_accel_z,
		input  ready
	);

	modport sink (
		input  valid, raw_gyro_x, raw_gyro_y, raw_gyro_z,
		       raw_accel_x, raw_accel_y, raw_accel_z,
		output ready
	);
endinterface

`default_nettype wire

// File: src/imual_body_if.sv
`default_nettype none

interface imual_body_if #(
	parameter int SAMPLE_BITS = imual_pkg::DEF_SAMPLE_BITS
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS+1:0] body_gyro_x;
	logic signed [SAMPLE_BITS+1:0] body_gyro_y;
	logic signed [SAMPLE_BITS+1:0] body_gyro_z;
	logic signed [SAMPLE_BITS+1:0] smooth_accel_x;
	logic signed [SAMPLE_BITS+1:0] smooth_accel_y;
	logic signed [SAMPLE_BITS+1:0] smooth_accel_z;

	modport source (
		output valid, body_gyro_x, body_gyro_y, body_gyro_z,
		       smooth_accel_x, smooth_accel_y, smooth_accel_z,
		input  ready
	);

	modport sink (
		input  valid, body_gyro_x, body_gyro_y, body_gyro_z,
		       smooth_accel_x, smooth_accel_y, smooth_accel_z,
		output ready
	);
endinterface

`default_nettype wire

// File: src/imu_axis_align_lowpass_top.sv
`default_nettype none

// Channel  Dir  Role    Beat contents
// -------  ---  ------  --------------------------------------------------
// raw      in   sink    raw_gyro_x/y/z, raw_accel_x/y/z (SAMPLE_BITS each)
// body     out  source  body_gyro_x/y/z, smooth_accel_x/y/z (SAMPLE_BITS+2)
// cfg      in   write   cfg_we, cfg_index, cfg_data (no read-back)
//
// One beat per cycle while body is ready. A taken beat passes the input register,
// the aligned register and the filter state / result register on its way to body.
// The filter recursion is not pipelined, so it sets the clock period.
// arst_n clears valids, config registers (identity matrix, zero biases) and
// filter state. Stalls: each stage loads when it is empty or the next one
// moves; raw.ready falls only when all three stages hold beats and body stalls.
module imu_axis_align_lowpass_top #(
	parameter int  SAMPLE_BITS     = imual_pkg::DEF_SAMPLE_BITS,
	parameter int  COEF_FRAC_BITS  = imual_pkg::DEF_COEF_FRAC_BITS,
	parameter int  STATE_FRAC_BITS = imual_pkg::DEF_STATE_FRAC_BITS,
	localparam int CFG_DATA_W      = (SAMPLE_BITS > imual_pkg::ROT_BITS) ?
	                                 SAMPLE_BITS : imual_pkg::ROT_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [imual_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]             cfg_data,
	imual_raw_if.sink                         raw,
	imual_body_if.source                      body
);
	import imual_pkg::*;

	localparam int OUT_W = SAMPLE_BITS + 2;

	// configuration registers
	logic        [ROT_BITS-1:0]    rotation_q;
	logic signed [SAMPLE_BITS-1:0] gyro_bias_q  [3];
	logic signed [SAMPLE_BITS-1:0] accel_bias_q [3];

	// pipeline
	logic                          valid_s1, valid_s2, valid_s3;
	logic                          load_s1, load_s2, load_s3;
	logic signed [SAMPLE_BITS-1:0] gyro_s1  [3];
	logic signed [SAMPLE_BITS-1:0] accel_s1 [3];
	logic signed [OUT_W-1:0]       gyro_al  [3];
	logic signed [OUT_W-1:0]       accel_al [3];
	logic signed [OUT_W-1:0]       gyro_s2  [3];
	logic signed [OUT_W-1:0]       accel_s2 [3];
	logic signed [OUT_W-1:0]       gyro_s3  [3];
	logic signed [OUT_W-1:0]       smooth   [3];
	logic                          filt_step;

	// --- configuration writes; index past the map is dropped ---
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotation_q <= ROT_RESET;
			for (int i = 0; i < 3; i++) begin
				gyro_bias_q[i]  <= '0;
				accel_bias_q[i] <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_MOUNT_ROTATION: rotation_q      <= cfg_data[ROT_BITS-1:0];
				REG_GYRO_BIAS_X:    gyro_bias_q[0]  <= cfg_data[SAMPLE_BITS-1:0];
				REG_GYRO_BIAS_Y:    gyro_bias_q[1]  <= cfg_data[SAMPLE_BITS-1:0];
				REG_GYRO_BIAS_Z:    gyro_bias_q[2]  <= cfg_data[SAMPLE_BITS-1:0];
				REG_ACCEL_BIAS_X:   accel_bias_q[0] <= cfg_data[SAMPLE_BITS-1:0];
				REG_ACCEL_BIAS_Y:   accel_bias_q[1] <= cfg_data[SAMPLE_BITS-1:0];
				REG_ACCEL_BIAS_Z:   accel_bias_q[2] <= cfg_data[SAMPLE_BITS-1:0];
				default:            ;
			endcase
		end
	end

	// --- flow control: a stage loads when empty or when it drains ---
	assign load_s3   = !valid_s3 || body.ready;
	assign load_s2   = !valid_s2 || load_s3;
	assign load_s1   = !valid_s1 || load_s2;
	assign raw.ready = load_s1;

	// filter state moves exactly once per beat that enters the result stage
	assign filt_step = load_s3 && valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (load_s1)
				valid_s1 <= raw.valid;
			if (load_s2)
				valid_s2 <= valid_s1;
			if (load_s3)
				valid_s3 <= valid_s2;
		end
	end

	// stage 1: input register
	always_ff @(posedge clk) begin
		if (load_s1 && raw.valid) begin
			gyro_s1[0]  <= raw.raw_gyro_x;
			gyro_s1[1]  <= raw.raw_gyro_y;
			gyro_s1[2]  <= raw.raw_gyro_z;
			accel_s1[0] <= raw.raw_accel_x;
			accel_s1[1] <= raw.raw_accel_y;
			accel_s1[2] <= raw.raw_accel_z;
		end
	end

	// stage 2: alignment
	imual_align #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_align_gyro (
		.rotation (rotation_q),
		.bias     (gyro_bias_q),
		.v        (gyro_s1),
		.o        (gyro_al)
	);

	imual_align #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_align_accel (
		.rotation (rotation_q),
		.bias     (accel_bias_q),
		.v        (accel_s1),
		.o        (accel_al)
	);

	always_ff @(posedge clk) begin
		if (load_s2 && valid_s1) begin
			gyro_s2  <= gyro_al;
			accel_s2 <= accel_al;
		end
	end

	// stage 3: gyro result register and per-axis filter state
	always_ff @(posedge clk) begin
		if (filt_step)
			gyro_s3 <= gyro_s2;
	end

	for (genvar a = 0; a < 3; a++) begin : g_axis
		imual_lowpass #(
			.SAMPLE_BITS     (SAMPLE_BITS),
			.COEF_FRAC_BITS  (COEF_FRAC_BITS),
			.STATE_FRAC_BITS (STATE_FRAC_BITS)
		) u_lowpass (
			.clk    (clk),
			.arst_n (arst_n),
			.step   (filt_step),
			.x      (accel_s2[a]),
			.y      (smooth[a])
		);
	end

	// --- output beat ---
	assign body.valid          = valid_s3;
	assign body.body_gyro_x    = gyro_s3[0];
	assign body.body_gyro_y    = gyro_s3[1];
	assign body.body_gyro_z    = gyro_s3[2];
	assign body.smooth_accel_x = smooth[0];
	assign body.smooth_accel_y = smooth[1];
	assign body.smooth_accel_z = smooth[2];

endmodule

`default_nettype wire

// File: src/imual_align.sv
`default_nettype none

// Mounting rotation (entries -1/0/+1) plus bias, saturated to SAMPLE_BITS+2.
module imual_align #(
	parameter int SAMPLE_BITS = imual_pkg::DEF_SAMPLE_BITS
) (
	input  logic        [imual_pkg::ROT_BITS-1:0] rotation,
	input  logic signed [SAMPLE_BITS-1:0]         bias [3],
	input  logic signed [SAMPLE_BITS-1:0]         v    [3],
	output logic signed [SAMPLE_BITS+1:0]         o    [3]
);
	import imual_pkg::*;

	localparam int OUT_W = SAMPLE_BITS + 2;
	localparam int SW    = SAMPLE_BITS + 3;

	logic signed [SW-1:0] sum [3];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			sum[r] = SW'(bias[r]);
			for (int c = 0; c < 3; c++) begin
				unique case (rot_code_t'(rotation[2*(3*r+c) +: 2]))
					ROT_PLUS:  sum[r] = sum[r] + SW'(v[c]);
					ROT_MINUS: sum[r] = sum[r] - SW'(v[c]);
					default:   ;
				endcase
			end
		end
	end

	// one guard bit: saturate when it disagrees with the output sign
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			if (sum[r][SW-1] != sum[r][SW-2])
				o[r] = sum[r][SW-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
			else
				o[r] = sum[r][OUT_W-1:0];
		end
	end

endmodule

`default_nettype wire

// File: src/imual_lowpass.sv
`default_nettype none

// One axis of the second-order low-pass. State advances on step;
// y is the current state rounded to sample units.
module imual_lowpass #(
	parameter int SAMPLE_BITS     = imual_pkg::DEF_SAMPLE_BITS,
	parameter int COEF_FRAC_BITS  = imual_pkg::DEF_COEF_FRAC_BITS,
	parameter int STATE_FRAC_BITS = imual_pkg::DEF_STATE_FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic signed [SAMPLE_BITS+1:0] x,
	output logic signed [SAMPLE_BITS+1:0] y
);
	import imual_pkg::*;

	localparam int OUT_W = SAMPLE_BITS + 2;
	localparam int CW    = COEF_FRAC_BITS + 2;
	localparam int XW    = OUT_W + STATE_FRAC_BITS;
	localparam int OW    = (XW > ST_BITS) ? XW : ST_BITS;
	localparam int PW    = OW + CW + 2;
	localparam int QW    = PW - COEF_FRAC_BITS;
	localparam int EW    = OW + 1;
	localparam int RW    = EW - STATE_FRAC_BITS;
	localparam int P1W   = CW + ST_BITS;
	localparam int P3W   = CW + XW;

	localparam logic signed [CW-1:0] A1 = CW'(coef_scaled(COEF_A1, COEF_FRAC_BITS));
	localparam logic signed [CW-1:0] A2 = CW'(coef_scaled(COEF_A2, COEF_FRAC_BITS));
	localparam logic signed [CW-1:0] B0 = CW'(coef_scaled(COEF_B0, COEF_FRAC_BITS));

	localparam logic signed [PW-1:0] ACC_HALF = PW'(1) <<< (COEF_FRAC_BITS - 1);
	localparam logic signed [EW-1:0] OUT_HALF = EW'(1) <<< (STATE_FRAC_BITS - 1);

	logic signed [ST_BITS-1:0] last_q;
	logic signed [ST_BITS-1:0] before_q;
	logic signed [ST_BITS-1:0] next_state;
	logic signed [XW-1:0]      xs;
	logic signed [P1W-1:0]     p1;
	logic signed [P1W-1:0]     p2;
	logic signed [P3W-1:0]     p3;
	logic signed [PW-1:0]      acc;
	logic signed [QW-1:0]      quo;
	logic signed [EW-1:0]      rnd;
	logic signed [RW-1:0]      units;

	assign xs = $signed({x, {STATE_FRAC_BITS{1'b0}}});

	// constant-coefficient products, summed exactly
	assign p1  = P1W'(A1) * P1W'(last_q);
	assign p2  = P1W'(A2) * P1W'(before_q);
	assign p3  = P3W'(B0) * P3W'(xs);
	assign acc = PW'(p1) + PW'(p2) + PW'(p3) + ACC_HALF;
	assign quo = QW'(acc >>> COEF_FRAC_BITS);

	always_comb begin
		if ((&quo[QW-1:ST_BITS-1]) || !(|quo[QW-1:ST_BITS-1]))
			next_state = quo[ST_BITS-1:0];
		else if (quo[QW-1])
			next_state = {1'b1, {(ST_BITS-1){1'b0}}};
		else
			next_state = {1'b0, {(ST_BITS-1){1'b1}}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q   <= '0;
			before_q <= '0;
		end else if (step) begin
			before_q <= last_q;
			last_q   <= next_state;
		end
	end

	// back to sample units, round half up, saturate
	assign rnd   = EW'(last_q) + OUT_HALF;
	assign units = RW'(rnd >>> STATE_FRAC_BITS);

	always_comb begin
		if ((&units[RW-1:OUT_W-1]) || !(|units[RW-1:OUT_W-1]))
			y = units[OUT_W-1:0];
		else if (units[RW-1])
			y = {1'b1, {(OUT_W-1){1'b0}}};
		else
			y = {1'b0, {(OUT_W-1){1'b1}}};
	end

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import imual_pkg::*;

	localparam int SB  = DEF_SAMPLE_BITS;
	localparam int OB  = SB + 2;
	localparam int CFB = DEF_COEF_FRAC_BITS;
	localparam int SFB = DEF_STATE_FRAC_BITS;
	localparam int CFG_W = (SB > ROT_BITS) ? SB : ROT_BITS;

	localparam int S_MAX = 2**(SB-1) - 1;
	localparam int S_MIN = -S_MAX - 1;

	// Low-pass taps, Q2.30 (a1 + a2 + b0 == 1.0)
	localparam logic signed [95:0] LP_A1   = 96'sd2071735500;
	localparam logic signed [95:0] LP_A2   = -96'sd1000494913;
	localparam logic signed [95:0] LP_B0   = 96'sd2501237;
	localparam logic signed [95:0] LP_HALF = 96'sd1 <<< (CFB - 1);
	localparam logic signed [95:0] ST_HI   = (96'sd1 <<< (ST_BITS - 1)) - 1;
	localparam logic signed [95:0] ST_LO   = -ST_HI - 1;
	localparam logic signed [63:0] OUT_HI  = (64'sd1 <<< (OB - 1)) - 1;
	localparam logic signed [63:0] OUT_LO  = -OUT_HI - 1;

	// Index past the register map; writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

	// Mounting matrices for the directed part
	localparam logic [ROT_BITS-1:0] ROT_ALL_PLUS   = 18'h15555;
	localparam logic [ROT_BITS-1:0] ROT_ALL_MINUS  = 18'h3FFFF;
	localparam logic [ROT_BITS-1:0] ROT_ALL_UNUSED = 18'h2AAAA;
	// x = -y, y = +z, z = -x
	localparam logic [ROT_BITS-1:0] ROT_SWAP       = 18'h0340C;

	localparam int RAND_PHASES  = 11;
	localparam int PHASE_BEATS  = 90;
	localparam int HOLD_AT      = 500;
	localparam int HOLD_LEN     = 300;
	localparam int DRAIN_CYCLES = 16;
	localparam int LIMIT_CYCLES = 200000;
	localparam int REPORT_CAP   = 50;
	localparam int IDLE_PCT     = 9;

	typedef enum int {
		MIX_UNIFORM,
		MIX_CORNER,
		MIX_STEP
	} stim_mix_t;

	typedef struct packed {
		logic [2:0][SB-1:0] gyro;
		logic [2:0][SB-1:0] accel;
	} raw_beat_t;

	typedef struct packed {
		logic [2:0][OB-1:0] gyro;
		logic [2:0][OB-1:0] accel;
	} body_beat_t;

	// ---------------------------------------------------------------
	// Clock, reset, DUT-facing signals (all known from time zero)
	// ---------------------------------------------------------------
	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;
	logic                 src_valid = 1'b0;
	raw_beat_t            src_beat  = '0;
	logic                 sink_ready = 1'b0;

	imual_raw_if  raw_ch ();
	imual_body_if body_ch ();

	assign raw_ch.valid       = src_valid;
	assign raw_ch.raw_gyro_x  = src_beat.gyro[0];
	assign raw_ch.raw_gyro_y  = src_beat.gyro[1];
	assign raw_ch.raw_gyro_z  = src_beat.gyro[2];
	assign raw_ch.raw_accel_x = src_beat.accel[0];
	assign raw_ch.raw_accel_y = src_beat.accel[1];
	assign raw_ch.raw_accel_z = src_beat.accel[2];
	assign body_ch.ready      = sink_ready;

	imu_axis_align_lowpass_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.raw       (raw_ch),
		.body      (body_ch)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Shadow of the block: register copy and filter history.
	// Starts at the reset state (identity matrix, zero offsets/state).
	// ---------------------------------------------------------------
	logic [ROT_BITS-1:0]       rot_cfg = ROT_RESET;
	logic signed [SB-1:0]      gyro_off [3] = '{default: '0};
	logic signed [SB-1:0]      accel_off [3] = '{default: '0};
	logic signed [ST_BITS-1:0] lp_last [3] = '{default: '0};
	logic signed [ST_BITS-1:0] lp_prev [3] = '{default: '0};

	raw_beat_t  pending [$];    // beats waiting for the driver
	body_beat_t want_body [$];  // predicted output beats, oldest first

	int  beats_queued = 0;
	int  beats_in     = 0;
	int  beats_out    = 0;
	int  mismatches   = 0;
	int  settings     = 1;
	int  cycle_count  = 0;
	bit  calm         = 1'b0;  // no random idling on either side while set
	int  hold_left    = 0;
	bit  hold_done    = 1'b0;
	string axes       = "xyz";

	function automatic logic signed [OB-1:0] clip_out(input logic signed [63:0] v);
		if (v > OUT_HI)
			return OUT_HI[OB-1:0];
		if (v < OUT_LO)
			return OUT_LO[OB-1:0];
		return v[OB-1:0];
	endfunction

	// One output row of matrix * vector + offset. The meaningless matrix
	// code falls through both tests and so counts as zero.
	function automatic logic signed [OB-1:0] align_axis(input logic [2:0][SB-1:0] vec,
			input logic signed [SB-1:0] off, input int row);
		logic signed [63:0] s;
		logic [1:0]         code;
		s = off;
		for (int c = 0; c < 3; c++) begin
			code = rot_cfg[2*(3*row + c) +: 2];
			if (code == ROT_PLUS)
				s = s + $signed(vec[c]);
			else if (code == ROT_MINUS)
				s = s - $signed(vec[c]);
		end
		return clip_out(s);
	endfunction

	// Work out the output beat for one accepted input beat and advance
	// the filter history.
	task automatic predict_body(input raw_beat_t b);
		body_beat_t                e;
		logic signed [OB-1:0]      ax;
		logic signed [95:0]        xs;
		logic signed [95:0]        acc;
		logic signed [ST_BITS-1:0] y;
		logic signed [63:0]        t;
		for (int r = 0; r < 3; r++) begin
			e.gyro[r] = align_axis(b.gyro, gyro_off[r], r);
			ax = align_axis(b.accel, accel_off[r], r);
			xs = ax;
			xs = xs <<< SFB;
			// exact sum of products, round half up, drop coefficient fraction
			acc = LP_A1 * lp_last[r] + LP_A2 * lp_prev[r] + LP_B0 * xs + LP_HALF;
			acc = acc >>> CFB;
			if (acc > ST_HI)
				y = ST_HI[ST_BITS-1:0];
			else if (acc < ST_LO)
				y = ST_LO[ST_BITS-1:0];
			else
				y = acc[ST_BITS-1:0];
			lp_prev[r] = lp_last[r];
			lp_last[r] = y;
			// back to sample units, round half up
			t = y;
			t = (t + (64'sd1 <<< (SFB - 1))) >>> SFB;
			e.accel[r] = clip_out(t);
		end
		want_body.push_back(e);
	endtask

	task automatic flag_mismatch(input string field, input int axis,
			input logic signed [OB-1:0] want, input logic signed [OB-1:0] got);
		if (mismatches < REPORT_CAP)
			$display("%0t ns  %s_%c  expected %0d  actual %0d",
			         $time, field, axes[axis], want, got);
		mismatches++;
	endtask

	// ---------------------------------------------------------------
	// Driver: offers queued beats, random gaps between beats.
	// Prediction happens here, at the edge where a beat is taken.
	// ---------------------------------------------------------------
	always @(posedge clk) begin : drive_raw
		raw_beat_t nxt;
		if (!arst_n) begin
			src_valid <= 1'b0;
		end else begin
			if (src_valid && raw_ch.ready) begin
				predict_body(src_beat);
				beats_in = beats_in + 1;
			end
			if (!src_valid || raw_ch.ready) begin
				if (pending.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
					nxt = pending.pop_front();
					src_beat  <= nxt;
					src_valid <= 1'b1;
				end else begin
					src_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Receiver: random ready drops plus one long hold-off once enough
	// beats are in, so the pipe fills and raw.ready must fall.
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			sink_ready <= 1'b0;
		end else if (hold_left != 0) begin
			sink_ready <= 1'b0;
			hold_left  <= hold_left - 1;
		end else if (!hold_done && beats_in >= HOLD_AT) begin
			sink_ready <= 1'b0;
			hold_left  <= HOLD_LEN;
			hold_done  <= 1'b1;
		end else begin
			sink_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// ---------------------------------------------------------------
	// Monitor: every output beat against the oldest prediction
	// ---------------------------------------------------------------
	always @(posedge clk) begin : watch_body
		body_beat_t got;
		body_beat_t want;
		if (arst_n && body_ch.valid && body_ch.ready) begin
			got.gyro[0]  = body_ch.body_gyro_x;
			got.gyro[1]  = body_ch.body_gyro_y;
			got.gyro[2]  = body_ch.body_gyro_z;
			got.accel[0] = body_ch.smooth_accel_x;
			got.accel[1] = body_ch.smooth_accel_y;
			got.accel[2] = body_ch.smooth_accel_z;
			beats_out++;
			if (want_body.size() == 0) begin
				if (mismatches < REPORT_CAP)
					$display("%0t ns  output beat with nothing expected", $time);
				mismatches++;
			end else begin
				want = want_body.pop_front();
				for (int i = 0; i < 3; i++) begin
					if (got.gyro[i] !== want.gyro[i])
						flag_mismatch("body_gyro", i, want.gyro[i], got.gyro[i]);
					if (got.accel[i] !== want.accel[i])
						flag_mismatch("smooth_accel", i, want.accel[i], got.accel[i]);
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("%0t ns  timeout after %0d cycles, %0d beats in, %0d out",
			         $time, cycle_count, beats_in, beats_out);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------
	function automatic logic signed [SB-1:0] rand_sample(input stim_mix_t mix,
			input logic signed [SB-1:0] level);
		int v;
		case (mix)
			MIX_CORNER: begin
				case ($urandom_range(0, 4))
					0: return SB'(S_MAX);
					1: return SB'(S_MIN);
					2: return '0;
					3: return '1;
					default: return SB'(1);
				endcase
			end
			MIX_STEP: begin
				// held level with a little noise, lets the filter settle
				v = level;
				v = v + int'($urandom_range(0, 128)) - 64;
				if (v > S_MAX)
					v = S_MAX;
				if (v < S_MIN)
					v = S_MIN;
				return v[SB-1:0];
			end
			default: return SB'($urandom);
		endcase
	endfunction

	function automatic raw_beat_t mk_beat(input int g0, input int g1, input int g2,
			input int a0, input int a1, input int a2);
		raw_beat_t b;
		b.gyro[0]  = g0[SB-1:0];
		b.gyro[1]  = g1[SB-1:0];
		b.gyro[2]  = g2[SB-1:0];
		b.accel[0] = a0[SB-1:0];
		b.accel[1] = a1[SB-1:0];
		b.accel[2] = a2[SB-1:0];
		return b;
	endfunction

	task automatic push_beat(input raw_beat_t b);
		pending.push_back(b);
		beats_queued++;
	endtask

	// Zero, full scale both ways, and mixed extremes
	task automatic push_corners();
		push_beat(mk_beat(0, 0, 0, 0, 0, 0));
		push_beat(mk_beat(S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX));
		push_beat(mk_beat(S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN));
		push_beat(mk_beat(S_MAX, S_MIN, 0, S_MIN, S_MAX, -1));
	endtask

	// Block until every queued beat is taken and its result has come back
	task automatic drain_expected();
		while (beats_in != beats_queued || want_body.size() != 0)
			@(posedge clk);
	endtask

	// One register write; the shadow copy follows. cfg_we is left high
	// so back-to-back writes need one assignment per edge.
	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx) inside
			REG_MOUNT_ROTATION:
				rot_cfg = data[ROT_BITS-1:0];
			REG_GYRO_BIAS_X, REG_GYRO_BIAS_Y, REG_GYRO_BIAS_Z:
				gyro_off[idx - REG_GYRO_BIAS_X] = data[SB-1:0];
			REG_ACCEL_BIAS_X, REG_ACCEL_BIAS_Y, REG_ACCEL_BIAS_Z:
				accel_off[idx - REG_ACCEL_BIAS_X] = data[SB-1:0];
			default: ;  // outside the map: dropped
		endcase
	endtask

	// Full register set; offset words carry junk above the sample width
	task automatic apply_setting(input logic [ROT_BITS-1:0] rot,
			input logic signed [SB-1:0] gb [3], input logic signed [SB-1:0] ab [3],
			input bit poke_spare);
		logic [CFG_W-1:0] word;
		for (int k = REG_MOUNT_ROTATION; k <= REG_ACCEL_BIAS_Z; k++) begin
			word = CFG_W'($urandom);
			if (k == REG_MOUNT_ROTATION)
				word = rot;
			else if (k <= REG_GYRO_BIAS_Z)
				word[SB-1:0] = gb[k - REG_GYRO_BIAS_X];
			else
				word[SB-1:0] = ab[k - REG_ACCEL_BIAS_X];
			put_reg(k[CFG_IDX_W-1:0], word);
		end
		if (poke_spare)
			put_reg(CFG_IDX_SPARE, CFG_W'($urandom));
		@(posedge clk);
		cfg_we <= 1'b0;
		settings++;
	endtask

	// ---------------------------------------------------------------
	// Sequence: directed settings, then random settings and streams
	// ---------------------------------------------------------------
	initial begin
		logic signed [SB-1:0] gb [3];
		logic signed [SB-1:0] ab [3];
		logic signed [SB-1:0] glvl [3];
		logic signed [SB-1:0] alvl [3];
		logic [ROT_BITS-1:0]  rot;
		raw_beat_t            b;
		stim_mix_t            mix;
		int                   left;
		int                   run;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: identity, no offsets
		push_corners();
		drain_expected();

		// all +1, largest offsets: row sums reach the top of the range
		gb = '{S_MAX, S_MAX, S_MAX};
		apply_setting(ROT_ALL_PLUS, gb, gb, 1'b0);
		push_corners();
		drain_expected();

		// all -1, most negative offsets
		gb = '{S_MIN, S_MIN, S_MIN};
		apply_setting(ROT_ALL_MINUS, gb, gb, 1'b0);
		push_corners();
		drain_expected();

		// unused code everywhere reads as zero: output is the offset;
		// a write past the map lands in between and must change nothing
		for (int i = 0; i < 3; i++) begin
			gb[i] = rand_sample(MIX_UNIFORM, '0);
			ab[i] = rand_sample(MIX_UNIFORM, '0);
		end
		apply_setting(ROT_ALL_UNUSED, gb, ab, 1'b1);
		push_corners();
		drain_expected();

		// signed axis swap
		gb = '{S_MAX, S_MIN, 0};
		ab = '{-1, 1, S_MIN};
		apply_setting(ROT_SWAP, gb, ab, 1'b0);
		push_corners();
		drain_expected();

		for (int p = 0; p < RAND_PHASES; p++) begin
			rot = ROT_BITS'($urandom);
			if (p == 0)
				rot = '0;
			for (int i = 0; i < 3; i++) begin
				gb[i] = rand_sample(($urandom_range(0, 3) == 0) ? MIX_CORNER : MIX_UNIFORM, '0);
				ab[i] = rand_sample(($urandom_range(0, 3) == 0) ? MIX_CORNER : MIX_UNIFORM, '0);
			end
			apply_setting(rot, gb, ab, (p % 3) == 1);
			calm = (p == 4);  // one whole phase at full rate
			left = PHASE_BEATS;
			while (left > 0) begin
				mix = stim_mix_t'($urandom_range(0, 2));
				run = $urandom_range(8, 40);
				if (run > left)
					run = left;
				for (int i = 0; i < 3; i++) begin
					glvl[i] = rand_sample(($urandom_range(0, 1) == 0) ? MIX_CORNER : MIX_UNIFORM, '0);
					alvl[i] = rand_sample(($urandom_range(0, 1) == 0) ? MIX_CORNER : MIX_UNIFORM, '0);
				end
				for (int k = 0; k < run; k++) begin
					for (int i = 0; i < 3; i++) begin
						b.gyro[i]  = rand_sample(mix, glvl[i]);
						b.accel[i] = rand_sample(mix, alvl[i]);
					end
					push_beat(b);
				end
				left -= run;
			end
			drain_expected();
			calm = 1'b0;
		end

		// anything extra the block still emits shows up as an orphan beat
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d input beats, %0d output beats checked over %0d register settings",
		         beats_in, beats_out, settings);
		$display("matrices: identity, +1, -1, unused, swap, random; %0d-cycle hold-off; %0d errs",
		         HOLD_LEN, mismatches);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
